// ===== rtl/scf_pkg.sv =====
package scf_pkg;

    localparam int FIFO_DEPTH_DEF = 256;

    // Function selector codes on the input channel.
    localparam logic [1:0] FUNC_SCAN = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // Action codes reported on the result channel.
    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_SAVE   = 4'd1;
    localparam logic [3:0] ACT_EXIT   = 4'd2;
    localparam logic [3:0] ACT_STOP   = 4'd3;
    localparam logic [3:0] ACT_SELECT = 4'd4;
    localparam logic [3:0] ACT_COPY   = 4'd5;
    localparam logic [3:0] ACT_PASTE  = 4'd6;
    localparam logic [3:0] ACT_UP     = 4'd7;
    localparam logic [3:0] ACT_DOWN   = 4'd8;
    localparam logic [3:0] ACT_LEFT   = 4'd9;
    localparam logic [3:0] ACT_RIGHT  = 4'd10;

    // Scancodes with a meaning of their own.
    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_CTRL     = 8'h1D;
    localparam logic [7:0] SC_CAPS     = 8'h3A;
    localparam logic [7:0] SC_NUMLOCK  = 8'h45;
    localparam logic [7:0] SC_KP_FIRST = 8'h47;
    localparam logic [7:0] SC_KP_LAST  = 8'h53;
    localparam logic [7:0] SC_KP_MUL   = 8'h37;
    localparam logic [7:0] SC_MAP_LEN  = 8'h59;
    localparam logic [7:0] SC_UP       = 8'h48;
    localparam logic [7:0] SC_DOWN     = 8'h50;
    localparam logic [7:0] SC_LEFT     = 8'h4B;
    localparam logic [7:0] SC_RIGHT    = 8'h4D;
    localparam logic [7:0] SC_KP_ENTER = 8'h1C;
    localparam logic [7:0] SC_KP_SLASH = 8'h35;
    localparam logic [7:0] SC_C_SAVE   = 8'h1F;
    localparam logic [7:0] SC_C_EXIT   = 8'h12;
    localparam logic [7:0] SC_C_STOP   = 8'h20;
    localparam logic [7:0] SC_C_SELECT = 8'h39;
    localparam logic [7:0] SC_C_COPY   = 8'h2E;
    localparam logic [7:0] SC_C_PASTE  = 8'h2F;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NONE    = 8'h00;

    typedef struct packed {
        logic       push_req;
        logic [7:0] push_char;
        logic [3:0] action;
    } dec_result_t;

    typedef struct packed {
        logic pushed;
        logic dropped;
        logic rd_hit;
        logic has_key;
    } fifo_status_t;

    function automatic logic [7:0] plain_char(input logic [6:0] idx);
        logic [7:0] ch;
        unique case (idx)
            7'd1:  ch = 8'h1B;
            7'd2:  ch = 8'h31;
            7'd3:  ch = 8'h32;
            7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;
            7'd6:  ch = 8'h35;
            7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;
            7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;
            7'd12: ch = 8'h2D;
            7'd13: ch = 8'h3D;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h61;
            7'd17: ch = 8'h7A;
            7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;
            7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;
            7'd22: ch = 8'h75;
            7'd23: ch = 8'h69;
            7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;
            7'd26: ch = 8'h5B;
            7'd27: ch = 8'h5D;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h71;
            7'd31: ch = 8'h73;
            7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;
            7'd35: ch = 8'h68;
            7'd36: ch = 8'h6A;
            7'd37: ch = 8'h6B;
            7'd38: ch = 8'h6C;
            7'd39: ch = 8'h6D;
            7'd40: ch = 8'h27;
            7'd41: ch = 8'h60;
            7'd43: ch = 8'h5C;
            7'd44: ch = 8'h77;
            7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;
            7'd48: ch = 8'h62;
            7'd49: ch = 8'h6E;
            7'd50: ch = 8'h3B;
            7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;
            7'd53: ch = 8'h2F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd71: ch = 8'h37;
            7'd72: ch = 8'h38;
            7'd73: ch = 8'h39;
            7'd74: ch = 8'h2D;
            7'd75: ch = 8'h34;
            7'd76: ch = 8'h35;
            7'd77: ch = 8'h36;
            7'd78: ch = 8'h2B;
            7'd79: ch = 8'h31;
            7'd80: ch = 8'h32;
            7'd81: ch = 8'h33;
            7'd82: ch = 8'h30;
            7'd83: ch = 8'h2E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_lower(input logic [7:0] ch);
        return (ch >= 8'h61) && (ch <= 8'h7A);
    endfunction

    // Shifted layout: punctuation differs, letters are the upper case of the plain layout.
    function automatic logic [7:0] shift_char(input logic [6:0] idx);
        logic [7:0] p;
        logic [7:0] ch;
        p = plain_char(idx);
        unique case (idx)
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h40;
            7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h24;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5E;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2A;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5F;
            7'd13: ch = 8'h2B;
            7'd26: ch = 8'h7B;
            7'd27: ch = 8'h7D;
            7'd40: ch = 8'h22;
            7'd41: ch = 8'h7E;
            7'd43: ch = 8'h7C;
            7'd50: ch = 8'h3A;
            7'd51: ch = 8'h3C;
            7'd52: ch = 8'h3E;
            7'd53: ch = 8'h3F;
            default: ch = is_lower(p) ? (p - 8'h20) : p;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/scf_decoder.sv =====
module scf_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           scan_byte,
    input  logic                 capture_on,
    output scf_pkg::dec_result_t result
);
    import scf_pkg::*;

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic caps_reg, caps_next;
    logic numpad_reg, numpad_next;
    logic prefix_reg, prefix_next;

    logic [6:0] low;
    logic [3:0] ctrl_act;
    logic [3:0] arrow_act;
    logic       is_keypad;
    logic [7:0] plain_ch;
    logic [7:0] map_ch;

    function automatic logic [3:0] ctrl_action(input logic [7:0] sc);
        logic [3:0] a;
        unique case (sc)
            SC_C_SAVE:   a = ACT_SAVE;
            SC_C_EXIT:   a = ACT_EXIT;
            SC_C_STOP:   a = ACT_STOP;
            SC_C_SELECT: a = ACT_SELECT;
            SC_C_COPY:   a = ACT_COPY;
            SC_C_PASTE:  a = ACT_PASTE;
            default:     a = ACT_NONE;
        endcase
        return a;
    endfunction

    function automatic logic [3:0] arrow_action(input logic [7:0] sc);
        logic [3:0] a;
        unique case (sc)
            SC_UP:    a = ACT_UP;
            SC_DOWN:  a = ACT_DOWN;
            SC_LEFT:  a = ACT_LEFT;
            SC_RIGHT: a = ACT_RIGHT;
            default:  a = ACT_NONE;
        endcase
        return a;
    endfunction

    assign low       = scan_byte[6:0];
    assign ctrl_act  = ctrl_action(scan_byte);
    assign arrow_act = arrow_action(scan_byte);
    assign is_keypad = (scan_byte >= SC_KP_FIRST) && (scan_byte <= SC_KP_LAST);
    assign plain_ch  = plain_char(low);

    always_comb
    begin
        if (is_keypad)
        begin
            map_ch = numpad_reg ? plain_ch : CH_NONE;
        end
        else if (shift_reg)
        begin
            map_ch = shift_char(low);
        end
        else if (caps_reg && is_lower(plain_ch))
        begin
            map_ch = plain_ch - 8'h20;
        end
        else
        begin
            map_ch = plain_ch;
        end
    end

    always_comb
    begin
        shift_next       = shift_reg;
        ctrl_next        = ctrl_reg;
        caps_next        = caps_reg;
        numpad_next      = numpad_reg;
        prefix_next      = prefix_reg;
        result.push_req  = 1'b0;
        result.push_char = CH_NONE;
        result.action    = ACT_NONE;
        priority if (scan_byte == SC_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else if (scan_byte[7])
        begin
            // Break codes: the modifier tests look at the code with the break bit removed.
            prefix_next = 1'b0;
            if ((low == SC_LSHIFT[6:0]) || (low == SC_RSHIFT[6:0]))
            begin
                shift_next = 1'b0;
            end
            if (low == SC_CTRL[6:0])
            begin
                ctrl_next = 1'b0;
            end
        end
        else if ((scan_byte == SC_LSHIFT) || (scan_byte == SC_RSHIFT))
        begin
            shift_next = 1'b1;
        end
        else if (scan_byte == SC_CTRL)
        begin
            ctrl_next = 1'b1;
        end
        else if (ctrl_reg && (ctrl_act != ACT_NONE))
        begin
            result.action = ctrl_act;
        end
        else if (scan_byte == SC_CAPS)
        begin
            caps_next = !caps_reg;
        end
        else if (scan_byte == SC_NUMLOCK)
        begin
            numpad_next = !numpad_reg;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
            if (arrow_act != ACT_NONE)
            begin
                if (capture_on)
                begin
                    result.push_req = 1'b1;
                end
                else
                begin
                    result.action = arrow_act;
                end
            end
            else if (scan_byte == SC_KP_ENTER)
            begin
                result.push_req  = 1'b1;
                result.push_char = CH_NEWLINE;
            end
            else if (scan_byte == SC_KP_SLASH)
            begin
                result.push_req  = 1'b1;
                result.push_char = CH_SLASH;
            end
        end
        else if (scan_byte == SC_KP_MUL)
        begin
            result.push_req  = 1'b1;
            result.push_char = CH_STAR;
        end
        else
        begin
            // Codes past the end of the key tables push nothing.
            result.push_req  = (scan_byte < SC_MAP_LEN) && (map_ch != CH_NONE);
            result.push_char = map_ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
            numpad_reg <= 1'b1;
            prefix_reg <= 1'b0;
        end
        else if (step_en)
        begin
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
            numpad_reg <= numpad_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== rtl/scf_fifo.sv =====
module scf_fifo #(
    parameter int FIFO_DEPTH = scf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_req,
    input  logic [7:0]            push_char,
    input  logic                  pop_req,
    input  logic                  peek_req,
    output scf_pkg::fifo_status_t status,
    output logic [7:0]            rd_data
);
    import scf_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [7:0]    mem [FIFO_DEPTH];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] wr_ptr_inc;
    logic [AW-1:0] rd_ptr_inc;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data_reg;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_ptr_inc = next_slot(wr_ptr_reg);
    assign rd_ptr_inc = next_slot(rd_ptr_reg);
    // One slot stays unused so that equal pointers always mean empty.
    assign full  = (wr_ptr_inc == rd_ptr_reg);
    assign empty = (rd_ptr_reg == wr_ptr_reg);
    assign wr_en = push_req && !full;
    assign rd_en = (pop_req || peek_req) && !empty;

    assign wr_ptr_next = wr_en ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = (rd_en && pop_req) ? rd_ptr_inc : rd_ptr_reg;

    assign status.pushed  = wr_en;
    assign status.dropped = push_req && full;
    assign status.rd_hit  = rd_en;
    assign status.has_key = (rd_ptr_next != wr_ptr_next);
    assign rd_data        = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= push_char;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    ptr_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rd_ptr_reg} < (AW + 1)'(FIFO_DEPTH))
        && ({1'b0, wr_ptr_reg} < (AW + 1)'(FIFO_DEPTH)))
        else $error("FIFO pointer beyond the last entry");

    drop_only_full_a: assert property (@(posedge clk) disable iff (!rst_n)
        status.dropped |-> (full && !status.pushed))
        else $error("character dropped while the FIFO had room");

    pop_advances_a: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && pop_req) |=> (rd_ptr_reg != $past(rd_ptr_reg)))
        else $error("pop transfer did not advance the read pointer");

endmodule

// ===== rtl/scancode_to_char_fifo_top.sv =====
// Set-1 keyboard scancode decoder with a character FIFO.
// Input channel (in_valid/in_ready) carries func and scan_byte: func selects a
// scancode byte, a pop or a peek. Every accepted transfer yields exactly one
// result on the output channel (out_valid/out_ready): the popped or peeked
// character, an action code, the push and drop flags and has_key.
// capture_on is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, as the block does not enforce this. When set,
// extended arrow keys push a zero character instead of an action.
// The accepting edge updates the decoder state and reads the character RAM;
// the registered read data joins the result in the output register when the
// first stage advances. One transfer is accepted every cycle unless the
// receiver stalls, a rate set by the single RAM port pair (one write, one read).
// Reset empties the FIFO, clears shift, ctrl, caps lock and the prefix, and
// sets num lock. RAM contents are not cleared; only written entries are read.
// When the receiver stalls, the result register and the stage before it fill
// and in_ready falls; nothing is lost and accepting resumes as soon as
// out_ready returns.
module scancode_to_char_fifo_top #(
    parameter int FIFO_DEPTH = scf_pkg::FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic [3:0] action,
    output logic       pushed,
    output logic       dropped,
    output logic       has_key
);
    import scf_pkg::*;

    logic         capture_on_reg;
    logic         in_xfer;
    logic         scan_step;
    dec_result_t  dec;
    fifo_status_t fst;
    logic [7:0]   rd_data;

    logic         s1_valid_reg;
    logic         s1_advance;
    logic         s1_rd_hit_reg;
    logic [3:0]   s1_action_reg;
    logic         s1_pushed_reg;
    logic         s1_dropped_reg;
    logic         s1_has_key_reg;

    logic         out_valid_reg;
    logic [7:0]   char_out_reg;
    logic         char_valid_reg;
    logic [3:0]   action_reg;
    logic         pushed_reg;
    logic         dropped_reg;
    logic         has_key_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;
    assign scan_step  = in_xfer && (func == FUNC_SCAN);

    scf_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (scan_step),
        .scan_byte  (scan_byte),
        .capture_on (capture_on_reg),
        .result     (dec)
    );

    scf_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (scan_step && dec.push_req),
        .push_char (dec.push_char),
        .pop_req   (in_xfer && (func == FUNC_POP)),
        .peek_req  (in_xfer && (func == FUNC_PEEK)),
        .status    (fst),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_on_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            capture_on_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_rd_hit_reg  <= fst.rd_hit;
            s1_action_reg  <= scan_step ? dec.action : ACT_NONE;
            s1_pushed_reg  <= fst.pushed;
            s1_dropped_reg <= fst.dropped;
            s1_has_key_reg <= fst.has_key;
        end
        // The RAM read data arrives in this stage and is merged here.
        if (s1_advance)
        begin
            char_out_reg   <= s1_rd_hit_reg ? rd_data : CH_NONE;
            char_valid_reg <= s1_rd_hit_reg;
            action_reg     <= s1_action_reg;
            pushed_reg     <= s1_pushed_reg;
            dropped_reg    <= s1_dropped_reg;
            has_key_reg    <= s1_has_key_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = char_out_reg;
    assign char_valid = char_valid_reg;
    assign action     = action_reg;
    assign pushed     = pushed_reg;
    assign dropped    = dropped_reg;
    assign has_key    = has_key_reg;

    s1_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("stalled result lost from the first stage");

    read_excludes_scan_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_valid_reg)
        |-> (!pushed_reg && !dropped_reg && (action_reg == ACT_NONE)))
        else $error("read result carries scancode flags");

    push_sets_key_a: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_pushed_reg) |-> s1_has_key_reg)
        else $error("FIFO reported empty right after a push");

endmodule

// ===== sim/tb_scancode_to_char_fifo_top.sv =====
`timescale 1ns / 100ps

module tb_scancode_to_char_fifo_top;
    import scf_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] SC_KEY_A    = 8'h10;
    localparam logic [7:0] SC_KEY_1    = 8'h02;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam int QUEUE_CAP = FIFO_DEPTH_DEF - 1;
    localparam int IDLE_PCT  = 12;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [3:0] action;
        logic       pushed;
        logic       dropped;
        logic       has_key;
    } key_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = FUNC_SCAN;
    logic [7:0] scan_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] char_out;
    logic       char_valid;
    logic [3:0] action;
    logic       pushed;
    logic       dropped;
    logic       has_key;

    scancode_to_char_fifo_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .scan_byte  (scan_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .char_valid (char_valid),
        .action     (action),
        .pushed     (pushed),
        .dropped    (dropped),
        .has_key    (has_key)
    );

    // Key layouts indexed by make code; the letter rows sit on the AZERTY positions.
    logic [7:0] plain_keys [0:88] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h3B, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic [7:0] shifted_keys [0:88] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h41, 8'h5A, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h51, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h57, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h3A, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic [7:0]  char_queue [$];
    key_result_t expected_q [$];
    logic        shift_down;
    logic        ctrl_down;
    logic        caps_active;
    logic        numpad_active;
    logic        e0_pending;
    logic        arrows_captured;
    bit          idle_on = 1'b1;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_stored = 0;
    int          n_lost = 0;
    int          n_actions = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not complete in time");
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Works out the result of one transfer and advances the keyboard and queue state.
    function automatic key_result_t decode_step(input logic [1:0] f, input logic [7:0] sc);
        key_result_t r;
        logic [7:0]  code;
        logic [7:0]  ch;
        logic [3:0]  dir;
        logic [3:0]  ctl;
        logic        store;
        r = '0;
        code = sc & ~BREAK_BIT;
        ch = CH_NONE;
        dir = ACT_NONE;
        ctl = ACT_NONE;
        store = 1'b0;
        case (code)
            SC_UP:    dir = ACT_UP;
            SC_DOWN:  dir = ACT_DOWN;
            SC_LEFT:  dir = ACT_LEFT;
            SC_RIGHT: dir = ACT_RIGHT;
            default:  ;
        endcase
        if (ctrl_down)
        begin
            case (code)
                SC_C_SAVE:   ctl = ACT_SAVE;
                SC_C_EXIT:   ctl = ACT_EXIT;
                SC_C_STOP:   ctl = ACT_STOP;
                SC_C_SELECT: ctl = ACT_SELECT;
                SC_C_COPY:   ctl = ACT_COPY;
                SC_C_PASTE:  ctl = ACT_PASTE;
                default:     ;
            endcase
        end
        if (f == FUNC_SCAN)
        begin
            if (sc == SC_PREFIX)
                e0_pending = 1'b1;
            else if (sc[7])
            begin
                e0_pending = 1'b0;
                if (code == SC_LSHIFT || code == SC_RSHIFT)
                    shift_down = 1'b0;
                if (code == SC_CTRL)
                    ctrl_down = 1'b0;
            end
            // Modifier, ctrl-combination and lock makes all leave the prefix pending.
            else if (code == SC_LSHIFT || code == SC_RSHIFT)
                shift_down = 1'b1;
            else if (code == SC_CTRL)
                ctrl_down = 1'b1;
            else if (ctl != ACT_NONE)
                r.action = ctl;
            else if (code == SC_CAPS)
                caps_active = !caps_active;
            else if (code == SC_NUMLOCK)
                numpad_active = !numpad_active;
            else if (e0_pending)
            begin
                e0_pending = 1'b0;
                if (dir != ACT_NONE)
                begin
                    if (arrows_captured)
                        store = 1'b1;
                    else
                        r.action = dir;
                end
                else if (code == SC_KP_ENTER)
                begin
                    ch = CH_NEWLINE;
                    store = 1'b1;
                end
                else if (code == SC_KP_SLASH)
                begin
                    ch = CH_SLASH;
                    store = 1'b1;
                end
            end
            else if (code == SC_KP_MUL)
            begin
                ch = CH_STAR;
                store = 1'b1;
            end
            else if (code < SC_MAP_LEN)
            begin
                if (code >= SC_KP_FIRST && code <= SC_KP_LAST)
                    ch = numpad_active ? plain_keys[code] : CH_NONE;
                else if (shift_down)
                    ch = shifted_keys[code];
                else
                begin
                    ch = plain_keys[code];
                    if (caps_active && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                        ch = ch - CASE_OFFSET;
                end
                store = (ch != CH_NONE);
            end
            if (store)
            begin
                if (char_queue.size() < QUEUE_CAP)
                begin
                    char_queue.push_back(ch);
                    r.pushed = 1'b1;
                end
                else
                    r.dropped = 1'b1;
            end
        end
        else if (f == FUNC_POP || f == FUNC_PEEK)
        begin
            if (char_queue.size() != 0)
            begin
                r.char_out = char_queue[0];
                r.char_valid = 1'b1;
                if (f == FUNC_POP)
                    void'(char_queue.pop_front());
            end
        end
        r.has_key = (char_queue.size() != 0);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] sc);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        scan_byte <= sc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(decode_step(f, sc));
        n_sent++;
    endtask

    task automatic press(input logic [7:0] sc);
        send_item(FUNC_SCAN, sc);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capture(input logic v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        arrows_captured = v;
    endtask

    task automatic random_access();
        int         pick;
        logic [7:0] junk;
        pick = $urandom_range(9);
        junk = 8'($urandom_range(255));
        if (pick < 6)
            send_item(FUNC_POP, junk);
        else if (pick < 9)
            send_item(FUNC_PEEK, junk);
        else
            send_item(FUNC_SPARE, junk);
    endtask

    // Mostly well-formed key strokes with random keys, the rest raw noise bytes.
    task automatic random_keystrokes();
        int         pick;
        logic [7:0] code;
        logic [7:0] modifier;
        pick = $urandom_range(99);
        code = 8'($urandom_range(88));
        modifier = ($urandom_range(1) == 1) ? SC_LSHIFT : SC_RSHIFT;
        if (pick < 40)
        begin
            press(code);
            if ($urandom_range(1) == 1)
                press(code | BREAK_BIT);
        end
        else if (pick < 52)
        begin
            press(modifier);
            press(code);
            press(code | BREAK_BIT);
            press(modifier | BREAK_BIT);
        end
        else if (pick < 60)
        begin
            case ($urandom_range(6))
                0:       code = SC_C_SAVE;
                1:       code = SC_C_EXIT;
                2:       code = SC_C_STOP;
                3:       code = SC_C_SELECT;
                4:       code = SC_C_COPY;
                5:       code = SC_C_PASTE;
                default: ;
            endcase
            press(SC_CTRL);
            press(code);
            press(SC_CTRL | BREAK_BIT);
        end
        else if (pick < 72)
        begin
            case ($urandom_range(6))
                0:       code = SC_UP;
                1:       code = SC_DOWN;
                2:       code = SC_LEFT;
                3:       code = SC_RIGHT;
                4:       code = SC_KP_ENTER;
                5:       code = SC_KP_SLASH;
                default: code = 8'($urandom_range(127));
            endcase
            press(SC_PREFIX);
            press(code);
            if ($urandom_range(1) == 1)
            begin
                press(SC_PREFIX);
                press(code | BREAK_BIT);
            end
        end
        else if (pick < 77)
            press(($urandom_range(1) == 1) ? SC_CAPS : SC_NUMLOCK);
        else
            press(8'($urandom_range(255)));
    endtask

    task automatic random_traffic(input int count, input int access_pct);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at)
        begin
            if ($urandom_range(99) < access_pct)
                random_access();
            else
                random_keystrokes();
        end
    endtask

    task automatic test_empty_queue();
        send_item(FUNC_POP, 8'hFF);
        send_item(FUNC_SPARE, 8'h00);
    endtask

    task automatic test_key_mapping();
        press(SC_KEY_A);
        press(SC_CAPS);
        press(SC_KEY_A);
        press(SC_LSHIFT);
        press(SC_KEY_1);
        press(SC_LSHIFT | BREAK_BIT);
        press(SC_KP_MUL);
        press(SC_NUMLOCK);
        press(SC_KP_FIRST);
        press(SC_NUMLOCK);
        send_item(FUNC_PEEK, 8'h00);
        send_item(FUNC_POP, 8'h00);
    endtask

    task automatic test_ctrl_actions();
        press(SC_CTRL);
        press(SC_C_SAVE);
        press(SC_C_EXIT);
        press(SC_C_STOP);
        press(SC_C_SELECT);
        press(SC_C_COPY);
        press(SC_C_PASTE);
        press(SC_CTRL | BREAK_BIT);
    endtask

    task automatic test_extended_keys();
        press(SC_PREFIX);
        press(SC_UP);
        press(SC_PREFIX);
        press(SC_KP_ENTER);
        press(SC_PREFIX);
        press(SC_KP_SLASH);
        // A shift make after the prefix leaves it pending, so the next key is still extended.
        press(SC_PREFIX);
        press(SC_RSHIFT);
        press(SC_RIGHT);
        press(SC_RSHIFT | BREAK_BIT);
    endtask

    task automatic test_capture_arrows();
        write_capture(1'b1);
        press(SC_PREFIX);
        press(SC_LEFT);
        press(SC_PREFIX);
        press(SC_DOWN);
    endtask

    task automatic test_capture_traffic();
        idle_on = 1'b0;
        random_traffic(300, 30);
        idle_on = 1'b1;
    endtask

    task automatic test_mixed_traffic();
        write_capture(1'b0);
        random_traffic(650, 30);
    endtask

    task automatic test_full_queue();
        // Mostly key strokes until the queue overflows, then mostly reads to empty it.
        random_traffic(550, 3);
        random_traffic(350, 80);
    endtask

    always @(posedge clk)
    begin : check_results
        key_result_t got;
        key_result_t want;
        if (out_valid && out_ready)
        begin
            got = {char_out, char_valid, action, pushed, dropped, has_key};
            n_checked++;
            if (got.pushed)
                n_stored++;
            if (got.dropped)
                n_lost++;
            if (got.action != ACT_NONE)
                n_actions++;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR %0t: unexpected result char=%h valid=%b action=%0d",
                             $realtime, got.char_out, got.char_valid, got.action);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("ERROR %0t: exp char=%h vld=%b act=%0d push=%b drop=%b key=%b",
                                 $realtime, want.char_out, want.char_valid, want.action,
                                 want.pushed, want.dropped, want.has_key);
                        $display("           got char=%h vld=%b act=%0d push=%b drop=%b key=%b",
                                 got.char_out, got.char_valid, got.action,
                                 got.pushed, got.dropped, got.has_key);
                    end
                end
            end
        end
    end

    initial
    begin
        shift_down = 1'b0;
        ctrl_down = 1'b0;
        caps_active = 1'b0;
        numpad_active = 1'b1;
        e0_pending = 1'b0;
        arrows_captured = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_key_mapping();
        test_ctrl_actions();
        test_extended_keys();
        test_capture_arrows();
        test_capture_traffic();
        test_mixed_traffic();
        test_full_queue();

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Covered %0d transfers: key mapping, ctrl actions, extended keys,",
                 n_sent);
        $display("capture on and off, queue overflow and drain.");
        $display("%0d results checked, %0d stored, %0d dropped, %0d actions.",
                 n_checked, n_stored, n_lost, n_actions);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== scancode_to_char_fifo_top.f =====
rtl/scf_pkg.sv
rtl/scf_decoder.sv
rtl/scf_fifo.sv
rtl/scancode_to_char_fifo_top.sv
sim/tb_scancode_to_char_fifo_top.sv
